// ===== hdl/rtc_pkg.sv =====
// Shared types, constants and character functions of the radix text converter.
package rtc_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int DIGIT_DEPTH_DEF = 64;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [5:0] DEC_BASE    = 6'd10;
  localparam logic [5:0] MIN_RADIX   = 6'd2;
  localparam logic [5:0] MAX_RADIX   = 6'd36;
  localparam logic [5:0] NOT_A_DIGIT = 6'd63;

  localparam logic [5:0] SOURCE_RESET = 6'd10;
  localparam logic [5:0] TARGET_RESET = 6'd16;

  localparam logic CFG_SOURCE_RADIX = 1'b0;
  localparam logic CFG_TARGET_RADIX = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_DIGIT = 2'd1;
  localparam logic [1:0] STATUS_BAD_RADIX = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic clear_rem;
  } div_ctrl_t;

  function automatic logic [5:0] char_value(input logic [7:0] ch);
    logic [5:0] v;
    v = NOT_A_DIGIT;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      v = 6'(ch - CH_ZERO);
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      v = 6'(ch - CH_UA) + DEC_BASE;
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      v = 6'(ch - CH_LA) + DEC_BASE;
    end
    return v;
  endfunction

  function automatic logic [6:0] value_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < DEC_BASE) begin
      c = 7'(CH_ZERO) + 7'(v);
    end else begin
      c = 7'(CH_UA) + 7'(v) - 7'(DEC_BASE);
    end
    return c;
  endfunction

endpackage

// ===== hdl/radix_text_converter.sv =====
// Top level of the radix text converter: parser, conversion sequencer and outputs.
//
// A number arrives as ASCII text, one byte per transfer on start/text_byte; a
// transfer happens at a clock edge where start is high and busy is low. A zero
// byte ends the number. Each digit byte passes through a single multiply-add,
// and busy stays low while digits arrive.
// On the terminator an error gives one result on the following cycle. Otherwise
// the accumulator is divided by target_radix in a shared restoring divider, one
// quotient bit per cycle, for each output digit. The digits are then read back
// from the digit store, most significant first, each through ST_READ and then
// ST_SEND, with busy high until the last digit has been sent.
// Each result is shown for one cycle with strobe high; the receiver cannot stall.
// The user must write registers via cfg_valid/cfg_ready/cfg_index/cfg_data only
// while the block is idle, which it does not enforce. cfg_ready is always high.
// A synchronous reset clears the number in progress and sets source_radix to 10
// and target_radix to 16.
module radix_text_converter #(
  parameter int VALUE_WIDTH = rtc_pkg::VALUE_WIDTH_DEF,
  parameter int DIGIT_DEPTH = rtc_pkg::DIGIT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] text_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  output logic       strobe,
  output logic [6:0] digit_char,
  output logic [6:0] digit_total,
  output logic [1:0] status,
  output logic       last_digit
);

  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int CW = $clog2(DIGIT_DEPTH + 1);
  localparam int SW = $clog2(VALUE_WIDTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_DIGIT = 5'b00100,
    ST_READ  = 5'b01000,
    ST_SEND  = 5'b10000
  } state_t;

  state_t                 state;
  logic [5:0]             source_radix;
  logic [5:0]             target_radix;
  logic [VALUE_WIDTH-1:0] accumulator;
  logic                   parse_failed;
  logic [CW-1:0]          stored_count;
  logic [SW-1:0]          step_cnt;
  logic [AW-1:0]          rd_ptr;

  logic                   accept;
  logic                   is_term;
  logic                   bad_radix;
  logic [5:0]             byte_value;
  logic [VALUE_WIDTH-1:0] product;
  rtc_pkg::div_ctrl_t     div_ctrl;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [5:0]             remainder;
  logic [5:0]             rd_data;
  logic                   stop_div;

  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = start && !busy;
  assign is_term    = (text_byte == rtc_pkg::CH_NUL);
  assign bad_radix  = (target_radix < rtc_pkg::MIN_RADIX) ||
                      (target_radix > rtc_pkg::MAX_RADIX);
  assign byte_value = rtc_pkg::char_value(text_byte);
  assign product    = accumulator * VALUE_WIDTH'(source_radix);
  assign stop_div   = (quotient == '0) || (stored_count == CW'(DIGIT_DEPTH - 1));

  assign div_ctrl.load      = accept && is_term && !parse_failed && !bad_radix;
  assign div_ctrl.step      = (state == ST_DIV);
  assign div_ctrl.clear_rem = (state == ST_DIGIT);

  rtc_div_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .ctrl      (div_ctrl),
    .load_value(accumulator),
    .divisor   (target_radix),
    .quotient  (quotient),
    .remainder (remainder)
  );

  rtc_digit_mem #(
    .DIGIT_DEPTH(DIGIT_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (state == ST_DIGIT),
    .wr_addr(stored_count[AW-1:0]),
    .wr_data(remainder),
    .rd_addr(rd_ptr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source_radix <= rtc_pkg::SOURCE_RESET;
      target_radix <= rtc_pkg::TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtc_pkg::CFG_SOURCE_RADIX: source_radix <= cfg_data;
        rtc_pkg::CFG_TARGET_RADIX: target_radix <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      accumulator  <= '0;
      parse_failed <= 1'b0;
      stored_count <= '0;
      step_cnt     <= '0;
      rd_ptr       <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!is_term) begin
              if (!parse_failed) begin
                if (byte_value >= source_radix) begin
                  parse_failed <= 1'b1;
                end else begin
                  accumulator <= product + VALUE_WIDTH'(byte_value);
                end
              end
            end else begin
              accumulator  <= '0;
              parse_failed <= 1'b0;
              stored_count <= '0;
              if (parse_failed || bad_radix) begin
                strobe      <= 1'b1;
                digit_char  <= 7'd0;
                digit_total <= 7'd0;
                status      <= parse_failed ? rtc_pkg::STATUS_BAD_DIGIT
                                            : rtc_pkg::STATUS_BAD_RADIX;
                last_digit  <= 1'b1;
              end else begin
                step_cnt <= '0;
                state    <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == SW'(VALUE_WIDTH - 1)) begin
            step_cnt <= '0;
            state    <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          stored_count <= stored_count + 1'b1;
          if (stop_div) begin
            rd_ptr <= stored_count[AW-1:0];
            state  <= ST_READ;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_READ: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          strobe      <= 1'b1;
          digit_char  <= rtc_pkg::value_char(rd_data);
          digit_total <= 7'(stored_count);
          status      <= rtc_pkg::STATUS_OK;
          last_digit  <= (rd_ptr == '0);
          if (rd_ptr == '0) begin
            stored_count <= '0;
            state        <= ST_IDLE;
          end else begin
            rd_ptr <= rd_ptr - 1'b1;
            state  <= ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rtc_div_unit.sv =====
// Shared restoring divider that produces one quotient bit per cycle in place while ctrl.step is high.
module rtc_div_unit #(
  parameter int VALUE_WIDTH = rtc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  rtc_pkg::div_ctrl_t     ctrl,
  input  logic [VALUE_WIDTH-1:0] load_value,
  input  logic [5:0]             divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [5:0]             remainder
);

  logic [VALUE_WIDTH-1:0] num;
  logic [5:0]             rem;
  logic [6:0]             rem_shift;
  logic [6:0]             rem_sub;
  logic                   fits;

  assign rem_shift = {rem, num[VALUE_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign fits      = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num <= load_value;
      rem <= 6'd0;
    end else if (ctrl.step) begin
      num <= {num[VALUE_WIDTH-2:0], fits};
      rem <= fits ? rem_sub[5:0] : rem_shift[5:0];
    end else if (ctrl.clear_rem) begin
      rem <= 6'd0;
    end
  end

  assign quotient  = num;
  assign remainder = rem;

endmodule

// ===== hdl/rtc_digit_mem.sv =====
// Digit store: one write port and one registered read port.
module rtc_digit_mem #(
  parameter int DIGIT_DEPTH = rtc_pkg::DIGIT_DEPTH_DEF,
  parameter int AW          = $clog2(DIGIT_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [5:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [5:0]    rd_data
);

  logic [5:0] mem [DIGIT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the radix text converter: directed and random text numbers against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int PHASE_ITEMS = 100;
  localparam int DIGIT_SLOTS = rtc_pkg::DIGIT_DEPTH_DEF;
  localparam int VALUE_BITS  = rtc_pkg::VALUE_WIDTH_DEF;

  typedef struct packed {
    logic [6:0] ch;
    logic [6:0] total;
    logic [1:0] stat;
    logic       last;
  } digit_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] text_byte = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_index = rtc_pkg::CFG_SOURCE_RADIX;
  logic [5:0] cfg_data = '0;
  logic       busy;
  logic       cfg_ready;
  logic       strobe;
  logic [6:0] digit_char;
  logic [6:0] digit_total;
  logic [1:0] status;
  logic       last_digit;

  logic [7:0]    text_queue[$];
  digit_result_t expected_digits[$];
  int            sender_gap_pct = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  logic [5:0]            source_radix_m = rtc_pkg::SOURCE_RESET;
  logic [5:0]            target_radix_m = rtc_pkg::TARGET_RESET;
  logic [VALUE_BITS-1:0] accum_m = '0;
  logic                  digit_fault_m = 1'b0;

  radix_text_converter uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .text_byte(text_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .digit_char(digit_char),
    .digit_total(digit_total),
    .status(status),
    .last_digit(last_digit)
  );

  always #5 clk = ~clk;

  function automatic logic [5:0] digit_of(input logic [7:0] b);
    if (b >= rtc_pkg::CH_ZERO && b <= rtc_pkg::CH_NINE) begin
      return 6'(b - rtc_pkg::CH_ZERO);
    end
    if (b >= rtc_pkg::CH_UA && b <= rtc_pkg::CH_UZ) begin
      return 6'(b - rtc_pkg::CH_UA + 8'd10);
    end
    if (b >= rtc_pkg::CH_LA && b <= rtc_pkg::CH_LZ) begin
      return 6'(b - rtc_pkg::CH_LA + 8'd10);
    end
    return rtc_pkg::NOT_A_DIGIT;
  endfunction

  function automatic logic [6:0] char_of(input logic [5:0] d);
    if (d < 6'd10) begin
      return 7'(rtc_pkg::CH_ZERO) + 7'(d);
    end
    return 7'(rtc_pkg::CH_UA) + 7'(d) - 7'd10;
  endfunction

  task automatic convert_text_byte(input logic [7:0] b);
    logic [5:0]            v;
    logic [VALUE_BITS-1:0] n;
    logic [5:0]            digs[DIGIT_SLOTS];
    int                    cnt;
    digit_result_t         r;
    if (b != rtc_pkg::CH_NUL) begin
      if (!digit_fault_m) begin
        v = digit_of(b);
        if (v >= source_radix_m) begin
          digit_fault_m = 1'b1;
        end else begin
          accum_m = accum_m * VALUE_BITS'(source_radix_m) + VALUE_BITS'(v);
        end
      end
    end else begin
      r = '0;
      r.last = 1'b1;
      if (digit_fault_m) begin
        r.stat = rtc_pkg::STATUS_BAD_DIGIT;
        expected_digits.push_back(r);
      end else if (target_radix_m < rtc_pkg::MIN_RADIX ||
                   target_radix_m > rtc_pkg::MAX_RADIX) begin
        r.stat = rtc_pkg::STATUS_BAD_RADIX;
        expected_digits.push_back(r);
      end else begin
        n = accum_m;
        cnt = 0;
        do begin
          digs[cnt] = 6'(n % VALUE_BITS'(target_radix_m));
          cnt++;
          n = n / VALUE_BITS'(target_radix_m);
        end while (n != 0 && cnt < DIGIT_SLOTS);
        for (int i = cnt - 1; i >= 0; i--) begin
          r.ch = char_of(digs[i]);
          r.total = 7'(cnt);
          r.stat = rtc_pkg::STATUS_OK;
          r.last = (i == 0);
          expected_digits.push_back(r);
        end
      end
      accum_m = '0;
      digit_fault_m = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    digit_result_t r;
    if (rst) begin
      source_radix_m = rtc_pkg::SOURCE_RESET;
      target_radix_m = rtc_pkg::TARGET_RESET;
      accum_m = '0;
      digit_fault_m = 1'b0;
    end else begin
      if (strobe) begin
        if (expected_digits.size() == 0) begin
          error_count++;
          $display("%0t: result expected none actual digit_char %0d status %0d", $time,
                   digit_char, status);
        end else begin
          r = expected_digits.pop_front();
          check_field("digit_char", r.ch, digit_char);
          check_field("digit_total", r.total, digit_total);
          check_field("status", r.stat, status);
          check_field("last_digit", r.last, last_digit);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rtc_pkg::CFG_SOURCE_RADIX) begin
          source_radix_m = cfg_data;
        end else begin
          target_radix_m = cfg_data;
        end
      end
      if (start && !busy) begin
        convert_text_byte(text_byte);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      text_byte <= '0;
    end else if (!start || !busy) begin
      if (text_queue.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
        start <= 1'b1;
        text_byte <= text_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_text(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) begin
      text_queue.push_back(s[i]);
    end
    if (terminate) begin
      text_queue.push_back(rtc_pkg::CH_NUL);
    end
  endtask

  task automatic wait_idle();
    while (text_queue.size() != 0 || start || expected_digits.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [5:0] pick_radix();
    case ($urandom_range(9))
      0: return 6'($urandom_range(1, 0));
      1: return 6'($urandom_range(63, 37));
      2: return rtc_pkg::MIN_RADIX;
      3: return rtc_pkg::MAX_RADIX;
      default: return 6'($urandom_range(36, 2));
    endcase
  endfunction

  function automatic logic [7:0] valid_char(input logic [5:0] radix);
    int limit;
    int v;
    limit = (radix > rtc_pkg::MAX_RADIX) ? 36 : radix;
    if (limit == 0) begin
      return rtc_pkg::CH_ZERO;
    end
    v = $urandom_range(limit - 1, 0);
    if (v < 10) begin
      return rtc_pkg::CH_ZERO + 8'(v);
    end
    return ($urandom_range(1) ? rtc_pkg::CH_UA : rtc_pkg::CH_LA) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] noise_char(input logic [5:0] radix);
    int v;
    if ($urandom_range(1) || radix >= rtc_pkg::MAX_RADIX) begin
      return 8'($urandom_range(255, 1));
    end
    v = $urandom_range(35, radix);
    if (v < 10) begin
      return rtc_pkg::CH_ZERO + 8'(v);
    end
    return ($urandom_range(1) ? rtc_pkg::CH_UA : rtc_pkg::CH_LA) + 8'(v - 10);
  endfunction

  initial begin : stimulus
    int         sent;
    int         len;
    int         noise_pos;
    logic [5:0] src;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sender_gap_pct = 30;

    queue_text("255", 1);
    queue_text("", 1);
    wait_idle();
    write_register(rtc_pkg::CFG_SOURCE_RADIX, rtc_pkg::MAX_RADIX);
    write_register(rtc_pkg::CFG_TARGET_RADIX, rtc_pkg::MAX_RADIX);
    queue_text("z", 0);
    wait_idle();
    write_register(rtc_pkg::CFG_SOURCE_RADIX, 6'd1);
    queue_text("0", 1);
    wait_idle();
    write_register(rtc_pkg::CFG_SOURCE_RADIX, 6'd63);
    write_register(rtc_pkg::CFG_TARGET_RADIX, rtc_pkg::MIN_RADIX);
    queue_text("zzzzzzzzzzz", 1);
    wait_idle();
    text_queue.push_back(8'hFF);
    queue_text("1", 1);
    wait_idle();
    write_register(rtc_pkg::CFG_SOURCE_RADIX, 6'd0);
    write_register(rtc_pkg::CFG_TARGET_RADIX, 6'd0);
    queue_text("0", 1);
    queue_text("", 1);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      sender_gap_pct = (phase == 0) ? 30 : (phase == 1) ? 75 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        src = pick_radix();
        write_register(rtc_pkg::CFG_SOURCE_RADIX, src);
        write_register(rtc_pkg::CFG_TARGET_RADIX, pick_radix());
        repeat (3) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(70, 13) : $urandom_range(12, 0);
          noise_pos = ($urandom_range(19) < 3) ? $urandom_range(len, 0) : -1;
          for (int i = 0; i <= len; i++) begin
            if (i == noise_pos) begin
              text_queue.push_back(noise_char(src));
              sent++;
            end
            if (i < len) begin
              text_queue.push_back(valid_char(src));
              sent++;
            end
          end
          text_queue.push_back(rtc_pkg::CH_NUL);
          sent++;
        end
        wait_idle();
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
